>>> design/pasmu_pkg.sv
`default_nettype none

package pasmu_pkg;

   // default polynomial length
   localparam int TERMS_DEF = 13;

   // field widths
   localparam int KIND_W = 3;
   localparam int POS_W  = 4;
   localparam int COEF_W = 32;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_SET_ACC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_OP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUB     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MUL     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

   // saturation limits of a q16.16 coefficient
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // tag that travels with each multiply-accumulate term
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_tag_type;

   // finished product coefficient
   typedef struct packed {
      logic              vld;
      logic              sat;
      logic [COEF_W-1:0] value;
   } mac_res_type;

endpackage

`default_nettype wire

>>> design/pasmu_ram.sv
`default_nettype none

module pasmu_ram
   import pasmu_pkg::*;
#(
   parameter int WIDTH = COEF_W,
   parameter int DEPTH = TERMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

>>> design/pasmu_mac.sv
`default_nettype none

module pasmu_mac
   import pasmu_pkg::*;
#(
   parameter int TERMS = TERMS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mac_tag_type               tag_in,
   input  wire logic signed [COEF_W-1:0]  acc_coef,
   input  wire logic signed [COEF_W-1:0]  op_coef,
   output logic                           busy,
   output mac_res_type                    res
);

   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * COEF_W;
   localparam int RND_W  = PROD_W - FRAC_W;
   localparam int SUM_W  = RND_W + $clog2(TERMS) + 1;
   localparam logic signed [PROD_W-1:0] HALF =
      {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

   mac_tag_type              tag_a_ff, tag_a_in;
   mac_tag_type              tag_b_ff, tag_b_in;
   mac_tag_type              tag_c_ff, tag_c_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [RND_W-1:0]  rnd_ff, rnd_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   mac_res_type              res_ff, res_in;
   logic signed [PROD_W-1:0] rsum;
   logic [SUM_W-COEF_W:0]    upper;

   always_comb begin
      // multiply stage
      tag_a_in = tag_in;
      prod_in  = acc_coef * op_coef;

      // round half up to q16.16
      tag_b_in = tag_a_ff;
      rsum     = prod_ff + HALF;
      rnd_in   = rsum[PROD_W-1:FRAC_W];

      // accumulate per exponent, restart on first term
      tag_c_in = tag_b_ff;
      sum_in   = sum_ff;
      if (tag_b_ff.vld) begin
         sum_in = (tag_b_ff.first ? '0 : sum_ff) + SUM_W'(rnd_ff);
      end

      // saturate finished sum
      upper      = sum_ff[SUM_W-1:COEF_W-1];
      res_in.vld = tag_c_ff.vld & tag_c_ff.last;
      res_in.sat = (upper != '0) && (upper != '1);
      if (res_in.sat) begin
         res_in.value = sum_ff[SUM_W-1] ? COEF_MIN : COEF_MAX;
      end else begin
         res_in.value = sum_ff[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      tag_a_ff <= tag_a_in;
      tag_b_ff <= tag_b_in;
      tag_c_ff <= tag_c_in;
      prod_ff  <= prod_in;
      rnd_ff   <= rnd_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      if (reset) begin
         tag_a_ff   <= '0;
         tag_b_ff   <= '0;
         tag_c_ff   <= '0;
         res_ff.vld <= 1'b0;
      end
   end

   assign busy = tag_a_ff.vld | tag_b_ff.vld | tag_c_ff.vld | res_ff.vld;
   assign res  = res_ff;

endmodule

`default_nettype wire

>>> design/polynomial_add_sub_mul_unit_top.sv
// set and load: write the coefficient, then the status result from the status state
// add and subtract: one coefficient per cycle, then the status result
// multiply: one term per cycle, then the status result once the products are written
// read out: one coefficient at a time via the single ram read port, issued to a free output
// one transaction at a time: the next is taken once the status or last coefficient is loaded
// reset: synchronous; a clearing pass zeroes every entry of both rams, input held off
`default_nettype none

module polynomial_add_sub_mul_unit_top
   import pasmu_pkg::*;
#(
   parameter int TERMS = TERMS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [COEF_W-1:0]  req_coef_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [POS_W-1:0]               rsp_out_position,
   output logic signed [COEF_W-1:0]       rsp_out_value,
   output logic [POS_W-1:0]               rsp_top_degree,
   output logic                           rsp_saturated,
   output logic                           rsp_last
);

   localparam int IDX_W = $clog2(TERMS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TERMS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_STATUS = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  mk_ff, mk_in;
   logic [IDX_W-1:0]  mj_ff, mj_in;
   logic [IDX_W-1:0]  wk_ff, wk_in;
   logic [IDX_W-1:0]  ad_ff, ad_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              sat_ff, sat_in;
   logic [TERMS-1:0]  nz_ff, nz_in;
   logic              issue_done_ff, issue_done_in;
   logic              rd_pend_ff, rd_pend_in;
   mac_tag_type       tag_rd_ff, tag_rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [COEF_W-1:0] out_val_ff, out_val_in;
   logic [POS_W-1:0]  out_top_ff, out_top_in;
   logic              out_sat_ff, out_sat_in;
   logic              out_last_ff, out_last_in;

   logic              acc_we, op_we;
   logic [IDX_W-1:0]  acc_waddr, acc_raddr, op_waddr, op_raddr;
   logic [COEF_W-1:0] acc_wdata, op_wdata, acc_rdata, op_rdata;

   logic              mac_busy;
   mac_res_type       mac_res;

   logic [IDX_W-1:0]  top_idx;
   logic [POS_W-1:0]  top_pos;
   logic              pos_ok;
   logic [IDX_W-1:0]  pos_idx;
   logic              out_free;
   logic [COEF_W:0]   as_sum;
   logic              as_ovf;
   logic [COEF_W-1:0] as_clip;

   // coefficient stores
   pasmu_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TERMS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   pasmu_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TERMS)
   ) u_op_ram (
      .clock   (clock),
      .wr_en   (op_we),
      .wr_addr (op_waddr),
      .wr_data (op_wdata),
      .rd_addr (op_raddr),
      .rd_data (op_rdata)
   );

   // multiply-accumulate unit used by the multiply
   pasmu_mac #(
      .TERMS (TERMS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .tag_in   (tag_rd_ff),
      .acc_coef (acc_rdata),
      .op_coef  (op_rdata),
      .busy     (mac_busy),
      .res      (mac_res)
   );

   // highest nonzero accumulator coefficient
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < TERMS; i++) begin
         if (nz_ff[i]) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign top_pos  = POS_W'(top_idx);
   assign pos_ok   = 32'(req_position) < 32'(TERMS);
   assign pos_idx  = IDX_W'(req_position);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // add or subtract with saturation
   always_comb begin
      if (kind_ff == KIND_SUB) begin
         as_sum = {acc_rdata[COEF_W-1], acc_rdata} - {op_rdata[COEF_W-1], op_rdata};
      end else begin
         as_sum = {acc_rdata[COEF_W-1], acc_rdata} + {op_rdata[COEF_W-1], op_rdata};
      end
      as_ovf = as_sum[COEF_W] != as_sum[COEF_W-1];
      if (as_ovf) begin
         as_clip = as_sum[COEF_W] ? COEF_MIN : COEF_MAX;
      end else begin
         as_clip = as_sum[COEF_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      mk_in         = mk_ff;
      mj_in         = mj_ff;
      wk_in         = wk_ff;
      ad_in         = ad_ff;
      kind_in       = kind_ff;
      sat_in        = sat_ff;
      nz_in         = nz_ff;
      issue_done_in = issue_done_ff;
      rd_pend_in    = rd_pend_ff;
      tag_rd_in     = '0;
      rsp_valid_in  = rsp_valid_ff;
      out_pos_in    = out_pos_ff;
      out_val_in    = out_val_ff;
      out_top_in    = out_top_ff;
      out_sat_in    = out_sat_ff;
      out_last_in   = out_last_ff;

      acc_we    = 1'b0;
      acc_waddr = idx_ff;
      acc_wdata = '0;
      acc_raddr = idx_ff;
      op_we     = 1'b0;
      op_waddr  = idx_ff;
      op_wdata  = '0;
      op_raddr  = idx_ff;

      // result transaction taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            acc_we = 1'b1;
            op_we  = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               sat_in        = 1'b0;
               issue_done_in = 1'b0;
               rd_pend_in    = 1'b0;
               idx_in        = '0;
               mk_in         = LAST_IDX;
               mj_in         = '0;
               wk_in         = LAST_IDX;
               unique case (req_kind) inside
                  KIND_SET_ACC: begin
                     if (pos_ok) begin
                        acc_we           = 1'b1;
                        acc_waddr        = pos_idx;
                        acc_wdata        = req_coef_value;
                        nz_in[pos_idx]   = req_coef_value != '0;
                     end
                     state_in = ST_STATUS;
                  end
                  KIND_LOAD_OP: begin
                     if (pos_ok) begin
                        op_we    = 1'b1;
                        op_waddr = pos_idx;
                        op_wdata = req_coef_value;
                     end
                     state_in = ST_STATUS;
                  end
                  KIND_ADD, KIND_SUB: begin
                     state_in = ST_ADD;
                  end
                  KIND_MUL: begin
                     state_in = ST_MUL;
                  end
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_STATUS;
                  end
               endcase
            end
         end

         ST_ADD: begin
            // read both coefficients, write the combination back in the next cycle
            if (!issue_done_ff) begin
               acc_raddr  = idx_ff;
               op_raddr   = idx_ff;
               rd_pend_in = 1'b1;
               ad_in      = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               rd_pend_in = 1'b0;
            end
            if (rd_pend_ff) begin
               acc_we       = 1'b1;
               acc_waddr    = ad_ff;
               acc_wdata    = as_clip;
               nz_in[ad_ff] = as_clip != '0;
               sat_in       = sat_ff | as_ovf;
            end
            if (issue_done_ff && !rd_pend_ff) begin
               state_in = ST_STATUS;
            end
         end

         ST_MUL: begin
            // exponents from the top down so each result overwrites a coefficient
            // that no later exponent reads
            if (!issue_done_ff) begin
               acc_raddr       = mj_ff;
               op_raddr        = mk_ff - mj_ff;
               tag_rd_in.vld   = 1'b1;
               tag_rd_in.first = mj_ff == '0;
               tag_rd_in.last  = mj_ff == mk_ff;
               if (mj_ff == mk_ff) begin
                  mj_in = '0;
                  if (mk_ff == '0) begin
                     issue_done_in = 1'b1;
                  end else begin
                     mk_in = mk_ff - 1'b1;
                  end
               end else begin
                  mj_in = mj_ff + 1'b1;
               end
            end
            if (mac_res.vld) begin
               acc_we       = 1'b1;
               acc_waddr    = wk_ff;
               acc_wdata    = mac_res.value;
               nz_in[wk_ff] = mac_res.value != '0;
               sat_in       = sat_ff | mac_res.sat;
               wk_in        = wk_ff - 1'b1;
            end
            if (issue_done_ff && !tag_rd_ff.vld && !mac_busy) begin
               state_in = ST_STATUS;
            end
         end

         ST_READ: begin
            // one coefficient in flight, issued only into an empty output register
            if (rd_pend_ff) begin
               rsp_valid_in = 1'b1;
               out_pos_in   = POS_W'(ad_ff);
               out_val_in   = acc_rdata;
               out_top_in   = top_pos;
               out_sat_in   = 1'b0;
               out_last_in  = ad_ff == LAST_IDX;
               rd_pend_in   = 1'b0;
            end else if (!issue_done_ff && !rsp_valid_ff) begin
               acc_raddr  = idx_ff;
               rd_pend_in = 1'b1;
               ad_in      = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (issue_done_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pos_in   = '0;
               out_val_in   = '0;
               out_top_in   = top_pos;
               out_sat_in   = sat_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      idx_ff        <= idx_in;
      mk_ff         <= mk_in;
      mj_ff         <= mj_in;
      wk_ff         <= wk_in;
      ad_ff         <= ad_in;
      kind_ff       <= kind_in;
      sat_ff        <= sat_in;
      nz_ff         <= nz_in;
      issue_done_ff <= issue_done_in;
      rd_pend_ff    <= rd_pend_in;
      tag_rd_ff     <= tag_rd_in;
      rsp_valid_ff  <= rsp_valid_in;
      out_pos_ff    <= out_pos_in;
      out_val_ff    <= out_val_in;
      out_top_ff    <= out_top_in;
      out_sat_ff    <= out_sat_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         sat_ff        <= 1'b0;
         nz_ff         <= '0;
         issue_done_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         tag_rd_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_position = out_pos_ff;
   assign rsp_out_value    = out_val_ff;
   assign rsp_top_degree   = out_top_ff;
   assign rsp_saturated    = out_sat_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

>>> design/pasmu_chk.sv
`default_nettype none

module pasmu_chk
   import pasmu_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [KIND_W-1:0]        req_kind,
   input wire logic [POS_W-1:0]         req_position,
   input wire logic signed [COEF_W-1:0] req_coef_value,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [POS_W-1:0]         rsp_out_position,
   input wire logic signed [COEF_W-1:0] rsp_out_value,
   input wire logic [POS_W-1:0]         rsp_top_degree,
   input wire logic                     rsp_saturated,
   input wire logic                     rsp_last
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_out_position, rsp_out_value, rsp_top_degree, rsp_saturated, rsp_last}))
      else $error("result changed while stalled");

   // clearing pass holds off input right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("input taken during clearing pass");

   // one transaction at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // only read out gives results that are not last, and those never saturate
   a_read_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_saturated)
      else $error("saturation flagged on read out");

   // a saturated status result carries no coefficient
   a_sat_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_last && rsp_out_value == '0 &&
         rsp_out_position == '0)
      else $error("saturated result is not a plain status");

endmodule

bind polynomial_add_sub_mul_unit_top pasmu_chk u_pasmu_chk (.*);

`default_nettype wire

>>> verif/polynomial_add_sub_mul_unit_top_tb.sv
`timescale 1ns / 1ps

module polynomial_add_sub_mul_unit_top_tb;
   import pasmu_pkg::*;

   localparam int TERMS = TERMS_DEF;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int MAX_REPORTS = 10;

   // unused transaction kinds
   localparam logic [KIND_W-1:0] KIND_SPARE_A  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B  = 3'd7;

   // q16.16 constants used by the directed part
   localparam logic [COEF_W-1:0] Q_ONE      = 32'h0001_0000;
   localparam logic [COEF_W-1:0] Q_TWO      = 32'h0002_0000;
   localparam logic [COEF_W-1:0] Q_HALF     = 32'h0000_8000;
   localparam logic [COEF_W-1:0] Q_NEG_ONE  = 32'hFFFF_0000;
   localparam logic [COEF_W-1:0] Q_LSB      = 32'h0000_0001;
   localparam logic [COEF_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [COEF_W-1:0] ZERO_COEF  = 32'h0000_0000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [COEF_W-1:0] value;
      logic [POS_W-1:0]  top;
      logic              sat;
      logic              last;
   } poly_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [COEF_W-1:0] req_coef_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [POS_W-1:0]         rsp_out_position;
   logic signed [COEF_W-1:0] rsp_out_value;
   logic [POS_W-1:0]         rsp_top_degree;
   logic                     rsp_saturated;
   logic                     rsp_last;

   // predictor state
   logic signed [COEF_W-1:0] acc_coef [TERMS];
   logic signed [COEF_W-1:0] opd_coef [TERMS];
   poly_rsp_type             poly_rsp_q [$];

   int     error_count = 0;
   int     sent_items = 0;
   int     burst_left = 0;
   bit     sender_gaps = 1'b1;
   int     hold_asked = 0;
   int     hold_served = 0;
   int     hold_left = 0;
   int     stall_cycle = 0;
   longint cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;

   polynomial_add_sub_mul_unit_top #(.TERMS(TERMS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_coef_value   (req_coef_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_position (rsp_out_position),
      .rsp_out_value    (rsp_out_value),
      .rsp_top_degree   (rsp_top_degree),
      .rsp_saturated    (rsp_saturated),
      .rsp_last         (rsp_last)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("polynomial_add_sub_mul_unit_top_tb NOT OK");
         $finish;
      end
   end

   // clip a wide sum to the q16.16 range
   function automatic logic [COEF_W-1:0] sat_coef(input longint v, output bit hit);
      hit = 1'b0;
      if (v > longint'($signed(COEF_MAX))) begin
         hit = 1'b1;
         return COEF_MAX;
      end
      if (v < longint'($signed(COEF_MIN))) begin
         hit = 1'b1;
         return COEF_MIN;
      end
      return v[COEF_W-1:0];
   endfunction

   // highest exponent with a nonzero accumulator coefficient
   function automatic logic [POS_W-1:0] top_acc_degree();
      for (int i = TERMS - 1; i >= 0; i--)
         if (acc_coef[i] != '0) return i[POS_W-1:0];
      return '0;
   endfunction

   // update the polynomial state and queue the results of one transaction
   task automatic predict_poly_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                  input logic [COEF_W-1:0] value);
      poly_rsp_type r;
      bit           clipped;
      bit           hit;
      longint       prod_sum [TERMS];
      logic [POS_W-1:0] top;
      clipped = 1'b0;
      case (kind)
         KIND_SET_ACC: begin
            if (pos < TERMS) acc_coef[pos] = value;
         end
         KIND_LOAD_OP: begin
            if (pos < TERMS) opd_coef[pos] = value;
         end
         KIND_ADD: begin
            for (int i = 0; i < TERMS; i++) begin
               acc_coef[i] = sat_coef(longint'(acc_coef[i]) + longint'(opd_coef[i]), hit);
               clipped |= hit;
            end
         end
         KIND_SUB: begin
            for (int i = 0; i < TERMS; i++) begin
               acc_coef[i] = sat_coef(longint'(acc_coef[i]) - longint'(opd_coef[i]), hit);
               clipped |= hit;
            end
         end
         KIND_MUL: begin
            // truncated product, each term rounded half up to q16.16
            for (int i = 0; i < TERMS; i++) prod_sum[i] = 0;
            for (int i = 0; i < TERMS; i++)
               for (int j = 0; i + j < TERMS; j++)
                  prod_sum[i+j] += (longint'(opd_coef[i]) * longint'(acc_coef[j]) + 32768) >>> 16;
            for (int i = 0; i < TERMS; i++) begin
               acc_coef[i] = sat_coef(prod_sum[i], hit);
               clipped |= hit;
            end
         end
         KIND_READ: begin
            top = top_acc_degree();
            for (int i = 0; i < TERMS; i++) begin
               r.pos   = i[POS_W-1:0];
               r.value = acc_coef[i];
               r.top   = top;
               r.sat   = 1'b0;
               r.last  = (i == TERMS - 1);
               poly_rsp_q.push_back(r);
            end
            return;
         end
         default: ;
      endcase
      r.pos   = '0;
      r.value = '0;
      r.top   = top_acc_degree();
      r.sat   = clipped;
      r.last  = 1'b1;
      poly_rsp_q.push_back(r);
   endtask

   // offer one transaction, idling between bursts, and predict it once accepted
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [COEF_W-1:0] value);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 25);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_position   <= pos;
      req_coef_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_poly_op(kind, pos, value);
      sent_items++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (poly_rsp_q.size() != 0);
   endtask

   // coefficient mix: extremes, sign boundary, full random, small magnitudes
   function automatic logic [COEF_W-1:0] rand_coef();
      int sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0, 1:    return ZERO_COEF;
         2:       return COEF_MAX;
         3:       return COEF_MIN;
         4:       return ALL_ONES;
         5, 6:    return $urandom;
         7, 8:    return $urandom_range(0, 1 << 24) - (1 << 23);
         default: return $urandom_range(0, 1 << 18) - (1 << 17);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      if ($urandom_range(0, 19) == 0) return POS_W'($urandom_range(TERMS, (1 << POS_W) - 1));
      return POS_W'($urandom_range(0, TERMS - 1));
   endfunction

   // result checker
   always @(posedge clock) begin
      poly_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (poly_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result: pos %0d value %h top %0d sat %0b last %0b",
                        rsp_out_position, rsp_out_value, rsp_top_degree, rsp_saturated,
                        rsp_last);
         end else begin
            want = poly_rsp_q.pop_front();
            if (rsp_out_position !== want.pos || rsp_out_value !== want.value ||
                rsp_top_degree !== want.top || rsp_saturated !== want.sat ||
                rsp_last !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("mismatch: exp pos %0d value %h top %0d sat %0b last %0b",
                           want.pos, want.value, want.top, want.sat, want.last);
                  $display("          got pos %0d value %h top %0d sat %0b last %0b",
                           rsp_out_position, rsp_out_value, rsp_top_degree, rsp_saturated,
                           rsp_last);
               end
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(posedge clock) begin
      stall_cycle++;
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (stall_cycle % 256 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 25);
            STALL_PERIODIC: rsp_stall <= (stall_cycle % 8 < 3);
            default:        rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
      end
   end

   // extremes, ignored positions, spare kinds, saturation and truncation
   task automatic test_directed();
      send_item(KIND_READ, 4'd0, ZERO_COEF);
      send_item(KIND_SET_ACC, 4'd0, COEF_MAX);
      send_item(KIND_SET_ACC, 4'd12, COEF_MIN);
      send_item(KIND_SET_ACC, 4'd13, Q_ONE);
      send_item(KIND_SET_ACC, 4'd15, ALL_ONES);
      send_item(KIND_LOAD_OP, 4'd0, COEF_MAX);
      send_item(KIND_LOAD_OP, 4'd12, COEF_MIN);
      send_item(KIND_LOAD_OP, 4'd14, ALL_ONES);
      send_item(KIND_ADD, 4'd0, ZERO_COEF);
      send_item(KIND_READ, 4'd15, ALL_ONES);
      send_item(KIND_SUB, 4'd0, ZERO_COEF);
      send_item(KIND_SUB, 4'd0, ZERO_COEF);
      send_item(KIND_SPARE_A, 4'd3, Q_ONE);
      send_item(KIND_SPARE_B, 4'd15, ALL_ONES);
      // small product: terms past degree 12 must drop out
      send_item(KIND_SET_ACC, 4'd0, Q_ONE);
      send_item(KIND_SET_ACC, 4'd1, Q_TWO);
      send_item(KIND_SET_ACC, 4'd12, Q_LSB);
      send_item(KIND_LOAD_OP, 4'd0, Q_HALF);
      send_item(KIND_LOAD_OP, 4'd1, Q_NEG_ONE);
      send_item(KIND_LOAD_OP, 4'd12, Q_LSB);
      send_item(KIND_MUL, 4'd0, ZERO_COEF);
      send_item(KIND_READ, 4'd0, ZERO_COEF);
      // product overflow
      send_item(KIND_SET_ACC, 4'd0, COEF_MAX);
      send_item(KIND_LOAD_OP, 4'd0, COEF_MIN);
      send_item(KIND_MUL, 4'd0, ZERO_COEF);
      send_item(KIND_READ, 4'd0, ZERO_COEF);
   endtask

   // coefficient writes followed by an operation, often read back
   task automatic test_arith_sequences(input int item_goal);
      int stop_at;
      int writes;
      int op_sel;
      stop_at = sent_items + item_goal;
      while (sent_items < stop_at) begin
         if ($urandom_range(0, 9) == 0) sender_gaps = !sender_gaps;
         if ($urandom_range(0, 6) == 0) begin
            // rebuild the whole accumulator with small values
            for (int i = 0; i < TERMS; i++)
               send_item(KIND_SET_ACC, i[POS_W-1:0],
                         ($urandom_range(0, 3) == 0) ? ZERO_COEF
                                                     : $urandom_range(0, 1 << 18) - (1 << 17));
         end else begin
            writes = $urandom_range(1, 6);
            for (int i = 0; i < writes; i++)
               send_item($urandom_range(0, 1) ? KIND_LOAD_OP : KIND_SET_ACC, rand_pos(),
                         rand_coef());
         end
         op_sel = $urandom_range(0, 9);
         if (op_sel < 3)      send_item(KIND_ADD, rand_pos(), rand_coef());
         else if (op_sel < 5) send_item(KIND_SUB, rand_pos(), rand_coef());
         else                 send_item(KIND_MUL, rand_pos(), rand_coef());
         if ($urandom_range(0, 9) < 4) send_item(KIND_READ, rand_pos(), rand_coef());
      end
      sender_gaps = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_full_stall();
      sender_gaps = 1'b0;
      hold_asked++;
      for (int i = 0; i < 40; i++) begin
         case ($urandom_range(0, 3))
            0:       send_item(KIND_READ, rand_pos(), rand_coef());
            1:       send_item(KIND_ADD, rand_pos(), rand_coef());
            default: send_item($urandom_range(0, 1) ? KIND_LOAD_OP : KIND_SET_ACC, rand_pos(),
                               rand_coef());
         endcase
      end
      sender_gaps = 1'b1;
      wait_results_drained();
   endtask

   // any kind, any position, any value
   task automatic test_random_noise(input int item_goal);
      for (int i = 0; i < item_goal; i++)
         send_item(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)),
                   POS_W'($urandom_range(0, (1 << POS_W) - 1)),
                   $urandom);
   endtask

   // test sequence
   initial begin
      for (int i = 0; i < TERMS; i++) begin
         acc_coef[i] = '0;
         opd_coef[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_results_drained();
      test_arith_sequences(380);
      wait_results_drained();
      test_full_stall();
      test_random_noise(60);
      wait_results_drained();
      repeat (200) @(posedge clock);
      if (poly_rsp_q.size() != 0) $display("%0d results never arrived", poly_rsp_q.size());
      if (error_count == 0 && poly_rsp_q.size() == 0) begin
         $display("polynomial_add_sub_mul_unit_top_tb OK");
      end else begin
         $display("polynomial_add_sub_mul_unit_top_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/pasmu_pkg.sv
design/pasmu_ram.sv
design/pasmu_mac.sv
design/polynomial_add_sub_mul_unit_top.sv
design/pasmu_chk.sv
verif/polynomial_add_sub_mul_unit_top_tb.sv
